>>> src/rpu_pkg.sv
`default_nettype none
package rpu_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int BYTE_W     = 8;
	localparam int DEPTH_W    = 5;
	localparam int MODE_W     = 2;
	localparam int LANES      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// color mode codes; the unused code behaves as mono
	localparam logic [MODE_W-1:0] MODE_MONO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BGR  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BYTE_FIRST = 2'd2;

	localparam logic [DEPTH_W-1:0] DEPTH_BYTE = 5'd8;
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = 5'd16;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [MODE_W-1:0]  color_mode;
		logic [DEPTH_W-1:0] bit_depth;
		logic               low_byte_first;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{color_mode: MODE_MONO, bit_depth: DEPTH_BYTE,
		low_byte_first: 1'b1};

endpackage
`default_nettype wire

>>> src/rpu_pix_if.sv
`default_nettype none
interface rpu_pix_if;
	import rpu_pkg::*;
	logic    valid;
	logic    ready;
	sample_t raw_first;
	sample_t raw_second;
	sample_t raw_third;

	modport source (output valid, output raw_first, output raw_second, output raw_third,
		input ready);
	modport sink (input valid, input raw_first, input raw_second, input raw_third,
		output ready);
endinterface
`default_nettype wire

>>> src/rpu_res_if.sv
`default_nettype none
interface rpu_res_if;
	import rpu_pkg::*;
	logic    valid;
	logic    ready;
	sample_t out_blue;
	sample_t out_green;
	sample_t out_red;
	sample_t out_grey;

	modport source (output valid, output out_blue, output out_green, output out_red,
		output out_grey, input ready);
	modport sink (input valid, input out_blue, input out_green, input out_red,
		input out_grey, output ready);
endinterface
`default_nettype wire

>>> src/rpu_cfg_if.sv
`default_nettype none
interface rpu_cfg_if;
	import rpu_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/raw_pixel_unpack_depth_expand_top.sv
// Raw pixel unpack with depth expansion: takes one pixel of up to three raw 16-bit samples per
// request and returns blue, green, red and grey channels, one result per pixel. Three lanes
// expand the samples side by side (byte order, bit replication for depths 9 to 15) into a
// stage register, and a merge stage reorders them into the output register. Throughput is one
// pixel per cycle while the output is not stalled; a pixel passes the stage register and then
// the output register before result valid. The two registers act as a two-deep buffer, so a
// new pixel is taken while a finished result waits if the stage register is free. Configuration
// writes are always accepted and must only be issued while no pixel is in flight.
`default_nettype none
module raw_pixel_unpack_depth_expand_top
	import rpu_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	rpu_pix_if.sink   pixel,
	rpu_res_if.source result,
	rpu_cfg_if.sink   cfg
);

	cfg_t              cfg_q;
	sample_t           raw [LANES];
	sample_t           lane_out [LANES];
	sample_t           samples_s1 [LANES];
	logic [MODE_W-1:0] mode_s1;
	logic              valid_s1;
	logic              ready_s1;
	logic              accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COLOR_MODE:     cfg_q.color_mode     <= cfg.data[MODE_W-1:0];
				REG_BIT_DEPTH:      cfg_q.bit_depth      <= cfg.data[DEPTH_W-1:0];
				REG_LOW_BYTE_FIRST: cfg_q.low_byte_first <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign raw[0] = pixel.raw_first;
	assign raw[1] = pixel.raw_second;
	assign raw[2] = pixel.raw_third;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		rpu_lane u_lane (
			.cfg    (cfg_q),
			.raw    (raw[i]),
			.sample (lane_out[i])
		);
	end

	assign pixel.ready = !valid_s1 || ready_s1;
	assign accept      = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samples_s1 <= lane_out;
			mode_s1    <= cfg_q.color_mode;
		end
	end

	rpu_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ready_s1   (ready_s1),
		.samples_s1 (samples_s1),
		.mode_s1    (mode_s1),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.blue       (result.out_blue),
		.green      (result.out_green),
		.red        (result.out_red),
		.grey       (result.out_grey)
	);

endmodule
`default_nettype wire

>>> src/rpu_lane.sv
`default_nettype none
module rpu_lane
	import rpu_pkg::*;
(
	input  wire cfg_t    cfg,
	input  wire sample_t raw,
	output sample_t      sample
);

	sample_t            assembled;
	sample_t            hi_part;
	sample_t            lo_part;
	logic [DEPTH_W-1:0] shl;
	logic [DEPTH_W-1:0] shr;
	logic [DEPTH_W-1:0] depth_dbl;

	// byte order only matters for two-byte samples
	assign assembled = cfg.low_byte_first ? raw : {raw[BYTE_W-1:0], raw[SAMPLE_W-1:BYTE_W]};

	// shift amounts are only used for depths 9 to 15
	assign depth_dbl = {cfg.bit_depth[DEPTH_W-2:0], 1'b0};
	assign shl       = DEPTH_FULL - cfg.bit_depth;
	assign shr       = depth_dbl - DEPTH_FULL;
	assign hi_part   = assembled << shl;
	assign lo_part   = assembled >> shr;

	always_comb begin
		if (cfg.bit_depth <= DEPTH_BYTE) begin
			sample = {{(SAMPLE_W-BYTE_W){1'b0}}, raw[BYTE_W-1:0]};
		end else if (cfg.bit_depth >= DEPTH_FULL) begin
			sample = assembled;
		end else begin
			sample = hi_part + lo_part;
		end
	end

endmodule
`default_nettype wire

>>> src/rpu_merge.sv
`default_nettype none
module rpu_merge
	import rpu_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid_s1,
	output logic                ready_s1,
	input  wire sample_t        samples_s1 [LANES],
	input  wire [MODE_W-1:0]    mode_s1,
	output logic                res_valid,
	input  wire                 res_ready,
	output sample_t             blue,
	output sample_t             green,
	output sample_t             red,
	output sample_t             grey
);

	logic    res_valid_q;
	sample_t blue_q;
	sample_t green_q;
	sample_t red_q;
	sample_t grey_q;

	assign ready_s1 = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ready_s1) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			case (mode_s1)
				MODE_RGB: begin
					blue_q  <= samples_s1[2];
					green_q <= samples_s1[1];
					red_q   <= samples_s1[0];
					grey_q  <= '0;
				end
				MODE_BGR: begin
					blue_q  <= samples_s1[0];
					green_q <= samples_s1[1];
					red_q   <= samples_s1[2];
					grey_q  <= '0;
				end
				default: begin
					blue_q  <= '0;
					green_q <= '0;
					red_q   <= '0;
					grey_q  <= samples_s1[0];
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign blue      = blue_q;
	assign green     = green_q;
	assign red       = red_q;
	assign grey      = grey_q;

endmodule
`default_nettype wire

>>> src/rpu_checker.sv
`default_nettype none
module rpu_checker
	import rpu_pkg::*;
(
	input wire          clk,
	input wire          arst_n,
	input wire          pix_valid,
	input wire          pix_ready,
	input wire          res_valid,
	input wire          res_ready,
	input wire sample_t blue,
	input wire sample_t green,
	input wire sample_t red,
	input wire sample_t grey
);

	logic pix_accept;
	assign pix_accept = pix_valid && pix_ready;

	// a result waiting for the sink stays
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// every accepted request shows result valid once it has passed the stage and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pix_accept |-> ##2 res_valid)
		else $error("result missing two cycles after request");

	// a new result needs a request in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !$past(res_valid) |-> $past(pix_accept, 2) || $past(res_valid, 2))
		else $error("result without request");

	// grey and color channels never both carry data
	a_grey_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && grey != '0 |-> blue == '0 && green == '0 && red == '0)
		else $error("grey and color channels both set");

endmodule

bind raw_pixel_unpack_depth_expand_top rpu_checker u_rpu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pixel.valid),
	.pix_ready (pixel.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.blue      (result.out_blue),
	.green     (result.out_green),
	.red       (result.out_red),
	.grey      (result.out_grey)
);
`default_nettype wire
